@@ rtl/itrd_pkg.sv @@
`timescale 1ns / 1ps

package itrd_pkg;

	// phase format
	localparam int PHASE_FRACTION_BITS = 32;
	localparam int ACC_BITS            = PHASE_FRACTION_BITS + 8;

	// field widths
	localparam int INC_BITS  = 33;
	localparam int OFF_BITS  = 36;
	localparam int RND_BITS  = 32;
	localparam int DIFF_BITS = OFF_BITS + 1;
	localparam int PROB_BITS = 33;
	localparam int SOFF_BITS = 32;

	// stream and configuration port widths
	localparam int S_DATA_BITS    = 104;
	localparam int M_DATA_BITS    = 8;
	localparam int CFG_DATA_BITS  = 33;
	localparam int CFG_INDEX_BITS = 2;

	// register indexes
	localparam logic [CFG_INDEX_BITS-1:0] CFG_DROP_PROBABILITY = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_START_OFFSET     = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_START_NEGATIVE   = 2'd2;

	// conversion shifts from 32 fraction bits
	localparam int SHL = (PHASE_FRACTION_BITS >= 32) ? PHASE_FRACTION_BITS - 32 : 0;
	localparam int SHR = (PHASE_FRACTION_BITS < 32) ? 32 - PHASE_FRACTION_BITS : 0;

	typedef logic signed [ACC_BITS-1:0] phase_t;

	localparam phase_t PH_ONE = {{(ACC_BITS-PHASE_FRACTION_BITS-1){1'b0}}, 1'b1,
		{PHASE_FRACTION_BITS{1'b0}}};

	typedef struct packed {
		logic   trig;
		phase_t ph;
	} wrap_t;

	typedef struct packed {
		logic dropped;
		logic impulse;
	} flags_t;

	// value with 32 fraction bits to phase format, wrapped to the accumulator
	function automatic phase_t to_phase(input logic signed [DIFF_BITS-1:0] v);
		logic signed [ACC_BITS+DIFF_BITS-1:0] ext;
		ext = (ACC_BITS+DIFF_BITS)'(v);
		if (PHASE_FRACTION_BITS >= 32) begin
			ext = ext <<< SHL;
		end else begin
			ext = ext >>> SHR;
		end
		return ext[ACC_BITS-1:0];
	endfunction

	// wrap test in the direction given by the last increment
	function automatic wrap_t wrap_test(input logic neg, input phase_t p);
		wrap_t  r;
		phase_t q;
		r.trig = 1'b0;
		r.ph   = p;
		q      = p;
		if (neg) begin
			if (p <= phase_t'(0)) begin
				r.trig = 1'b1;
				q      = p + PH_ONE;
				if (q > phase_t'(0)) begin
					r.ph = q;
				end else if (q[PHASE_FRACTION_BITS-1:0] == '0) begin
					r.ph = '0;
				end else begin
					// x - ceil(x) keeps the fraction bits under an all-ones integer part
					r.ph = {{(ACC_BITS-PHASE_FRACTION_BITS){1'b1}},
						q[PHASE_FRACTION_BITS-1:0]};
				end
			end
		end else begin
			if (p >= PH_ONE) begin
				r.trig = 1'b1;
				q      = p - PH_ONE;
				if (q >= PH_ONE) begin
					r.ph = {{(ACC_BITS-PHASE_FRACTION_BITS){1'b0}},
						q[PHASE_FRACTION_BITS-1:0]};
				end else begin
					r.ph = q;
				end
			end
		end
		return r;
	endfunction

endpackage

@@ rtl/itrd_phase.sv @@
`timescale 1ns / 1ps

module itrd_phase (
	input  itrd_pkg::phase_t                      acc,
	input  logic                                  last_neg,
	input  itrd_pkg::phase_t                      diff_ph,
	input  itrd_pkg::phase_t                      inc_ph,
	input  logic [itrd_pkg::RND_BITS-1:0]         rnd,
	input  logic [itrd_pkg::PROB_BITS-1:0]        drop_prob,
	output itrd_pkg::phase_t                      acc_next,
	output itrd_pkg::flags_t                      flags
);
	import itrd_pkg::*;

	wrap_t  trig_w;
	wrap_t  silent_w;
	phase_t shifted;
	logic   drop;

	// audible wrap test on the stored phase
	assign trig_w = wrap_test(last_neg, acc);

	// dropout decision
	assign drop = trig_w.trig && ({1'b0, rnd} < drop_prob);

	// offset change, then silent wrap in the old direction
	assign shifted  = trig_w.ph + diff_ph;
	assign silent_w = wrap_test(last_neg, shifted);

	// advance by the new increment
	assign acc_next = silent_w.ph + inc_ph;

	assign flags.impulse = trig_w.trig && !drop;
	assign flags.dropped = drop;

endmodule

@@ rtl/impulse_train_with_random_dropout.sv @@
`timescale 1ns / 1ps

// Impulse train with random dropout.
// One sample transaction on the s_ side gives one result transaction on the m_ side.
// s_tdata carries the signed phase increment, the signed phase offset and a uniform
// random word; m_tdata carries the impulse and dropped flags.
// A result passes through one input stage that forms the offset change, then
// through the output register.
// Throughput: one sample per cycle while the output is not stalled; the phase
// accumulator update (wrap test, offset add, silent wrap, increment add) is
// combinational.
// While m_tready is low one more sample is taken into the input stage, after which
// s_tready drops until the waiting result is taken.
// Configuration goes through cfg_we/cfg_index/cfg_data; the user writes it only while the
// block is idle, which the block does not enforce. A write to start_offset or start_negative
// reloads the phase state as at reset. Reset clears the registers to zero and loads the phase
// with one, a positive wrap direction and a zero last offset; the pipeline comes up empty.
module impulse_train_with_random_dropout (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// phase_increment[32:0], phase_offset[68:33], random_value[100:69], zero fill
	input  logic [itrd_pkg::S_DATA_BITS-1:0]       s_tdata,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// impulse[0], dropped[1], zero fill
	output logic [itrd_pkg::M_DATA_BITS-1:0]       m_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	input  logic                                   cfg_we,
	input  logic [itrd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [itrd_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
	import itrd_pkg::*;

	// configuration registers
	logic [PROB_BITS-1:0] drop_prob_q;
	logic [SOFF_BITS-1:0] start_offset_q;
	logic                 start_neg_q;

	// phase state
	phase_t                     acc_q;
	logic                       last_neg_q;
	logic signed [OFF_BITS-1:0] last_off_q;

	// input stage
	logic                 valid_s1;
	logic                 inc_neg_s1;
	phase_t               inc_ph_s1;
	phase_t               diff_ph_s1;
	logic [RND_BITS-1:0]  rnd_s1;

	// output register
	logic                 m_valid_q;
	flags_t               flags_q;

	logic signed [INC_BITS-1:0]  in_inc;
	logic signed [OFF_BITS-1:0]  in_off;
	logic [RND_BITS-1:0]         in_rnd;
	logic signed [DIFF_BITS-1:0] off_diff;
	logic                        out_free;
	logic                        adv_s1;
	logic                        in_take;
	phase_t                      acc_next;
	flags_t                      flags_next;
	logic [SOFF_BITS-1:0]        load_soff;
	logic                        load_neg;
	phase_t                      load_conv;
	phase_t                      load_ph;
	logic                        load_en;

	// unpack the sample
	assign in_inc = s_tdata[INC_BITS-1:0];
	assign in_off = s_tdata[INC_BITS+OFF_BITS-1:INC_BITS];
	assign in_rnd = s_tdata[INC_BITS+OFF_BITS+RND_BITS-1:INC_BITS+OFF_BITS];

	assign off_diff = DIFF_BITS'(in_off) - DIFF_BITS'(last_off_q);

	// handshake
	assign out_free = !m_valid_q || m_tready;
	assign adv_s1   = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign in_take  = s_tvalid && s_tready;

	// state reload from the start registers, with the value being written
	assign load_soff = (cfg_index == CFG_START_OFFSET) ? cfg_data[SOFF_BITS-1:0]
		: start_offset_q;
	assign load_neg  = (cfg_index == CFG_START_NEGATIVE) ? cfg_data[0] : start_neg_q;
	assign load_conv = to_phase(DIFF_BITS'(load_soff));
	assign load_ph   = (load_conv == '0 && !load_neg) ? PH_ONE : load_conv;
	assign load_en   = cfg_we && (cfg_index == CFG_START_OFFSET
		|| cfg_index == CFG_START_NEGATIVE);

	itrd_phase u_phase (
		.acc       (acc_q),
		.last_neg  (last_neg_q),
		.diff_ph   (diff_ph_s1),
		.inc_ph    (inc_ph_s1),
		.rnd       (rnd_s1),
		.drop_prob (drop_prob_q),
		.acc_next  (acc_next),
		.flags     (flags_next)
	);

	// configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_prob_q    <= '0;
			start_offset_q <= '0;
			start_neg_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DROP_PROBABILITY: drop_prob_q    <= cfg_data[PROB_BITS-1:0];
				CFG_START_OFFSET:     start_offset_q <= cfg_data[SOFF_BITS-1:0];
				CFG_START_NEGATIVE:   start_neg_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// phase state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= PH_ONE;
			last_neg_q <= 1'b0;
			last_off_q <= '0;
		end else if (load_en) begin
			acc_q      <= load_ph;
			last_neg_q <= load_neg;
			last_off_q <= OFF_BITS'(load_soff);
		end else begin
			if (adv_s1) begin
				acc_q      <= acc_next;
				last_neg_q <= inc_neg_s1;
			end
			if (in_take) begin
				last_off_q <= in_off;
			end
		end
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			inc_neg_s1 <= in_inc[INC_BITS-1];
			inc_ph_s1  <= to_phase(DIFF_BITS'(in_inc));
			diff_ph_s1 <= to_phase(off_diff);
			rnd_s1     <= in_rnd;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			flags_q <= flags_next;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(M_DATA_BITS-2){1'b0}}, flags_q.dropped, flags_q.impulse};

	// an impulse and a drop never come together
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("impulse and dropped both set");

	// zero drop probability never drops
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && drop_prob_q == '0) |-> !m_tdata[1])
		else $error("drop with zero probability");

	// full drop probability never lets an impulse through
	a_all_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && drop_prob_q[PROB_BITS-1]) |-> !m_tdata[0])
		else $error("impulse with full drop probability");

	// input stalls only behind a waiting result and a full input stage
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready && valid_s1))
		else $error("input stalled without cause");

endmodule

@@ sim/impulse_train_with_random_dropout_tb.sv @@
`timescale 1ns / 1ps

module impulse_train_with_random_dropout_tb;

	import itrd_pkg::*;

	localparam int     HALF_PERIOD  = 10;
	localparam int     RESET_CYCLES = 7;
	localparam int     QUIET_LIMIT  = 2000;
	localparam int     HOLD_CYCLES  = 300;
	localparam int     MAX_REPORTS  = 40;
	localparam int     MAX_WAIT     = 14;

	// index with no register behind it, writes there must be ignored
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_INDEX = 2'd3;

	localparam longint ACC_ONE     = 64'sd1 <<< PHASE_FRACTION_BITS;
	localparam longint ACC_FRAC    = ACC_ONE - 1;
	localparam longint WORD_MAX    = 64'sh0000_0000_FFFF_FFFF;
	localparam longint OFF_MAX     = 64'sh0000_0007_FFFF_FFFF;
	localparam longint OFF_MIN     = -64'sh0000_0008_0000_0000;
	localparam longint DROP_ALWAYS = 64'sh0000_0001_0000_0000;
	localparam longint DROP_MASK   = 64'sh0000_0001_FFFF_FFFF;

	logic                      clk;
	logic                      arst_n;
	// phase_increment[32:0], phase_offset[68:33], random_value[100:69], zero fill
	logic [S_DATA_BITS-1:0]    s_tdata;
	logic                      s_tvalid;
	logic                      s_tready;
	// impulse[0], dropped[1], zero fill
	logic [M_DATA_BITS-1:0]    m_tdata;
	logic                      m_tvalid;
	logic                      m_tready;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	// own copy of the block's registers and phase state
	longint drop_thresh;
	longint start_offset_reg;
	bit     start_neg_reg;
	longint acc_phase;
	longint model_last_inc;
	longint prev_off;

	flags_t pending_flags[$];

	int mismatch_count = 0;
	int results_seen   = 0;
	int quiet_cycles   = 0;
	int hold_len       = 0;
	bit tx_idle_on     = 1'b1;
	bit rx_idle_on     = 1'b1;

	impulse_train_with_random_dropout uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	// two's complement wrap to the accumulator width
	function automatic longint fold_acc(input longint v);
		phase_t t;
		t = v[ACC_BITS-1:0];
		return longint'(t);
	endfunction

	// 32 fraction bits to the accumulator's fraction width
	function automatic longint scale_to_acc(input longint v);
		if (PHASE_FRACTION_BITS >= 32) begin
			return v <<< SHL;
		end
		return v >>> SHR;
	endfunction

	// wrap check on acc_phase, direction from the sign of the last increment
	function automatic bit phase_wrap(input bit neg);
		longint p;
		p = acc_phase;
		if (neg) begin
			if (p > 0) begin
				return 1'b0;
			end
			p = p + ACC_ONE;
			// still at or below zero: drop the integer part, x - ceil(x)
			if (p <= 0) begin
				p = -((-p) & ACC_FRAC);
			end
		end else begin
			if (p < ACC_ONE) begin
				return 1'b0;
			end
			p = p - ACC_ONE;
			if (p >= ACC_ONE) begin
				p = p & ACC_FRAC;
			end
		end
		acc_phase = fold_acc(p);
		return 1'b1;
	endfunction

	// phase state as after reset, from the start registers
	function automatic void reload_phase();
		longint p;
		p = scale_to_acc(start_offset_reg);
		if (p == 0 && !start_neg_reg) begin
			p = ACC_ONE;
		end
		acc_phase = fold_acc(p);
		model_last_inc = start_neg_reg ? -64'sd1 : 64'sd0;
		prev_off  = start_offset_reg;
	endfunction

	// flags one sample produces, advancing the phase state
	function automatic flags_t next_impulse_flags(input longint inc, input longint off,
		input longint rnd);
		flags_t f;
		bit     trig;
		bit     drop;
		trig = phase_wrap(model_last_inc < 0);
		drop = trig && (rnd < drop_thresh);
		// offset change, then a silent wrap in the old direction
		acc_phase = fold_acc(acc_phase + scale_to_acc(off - prev_off));
		void'(phase_wrap(model_last_inc < 0));
		model_last_inc = inc;
		acc_phase = fold_acc(acc_phase + scale_to_acc(inc));
		prev_off  = off;
		f.impulse = trig && !drop;
		f.dropped = drop;
		return f;
	endfunction

	function automatic int draw_wait(input bit on);
		return on ? int'($urandom_range(MAX_WAIT, 0)) : 0;
	endfunction

	function automatic longint rand_bits(input int n);
		longint v;
		v = {$urandom, $urandom};
		return v & ((64'sd1 <<< n) - 1);
	endfunction

	// increment sizes from slow tones up to nearly one cycle per sample
	function automatic longint draw_magnitude();
		case ($urandom_range(3, 0))
			0: return longint'($urandom_range(32'h0100_0000, 0));
			1: return longint'($urandom_range(32'h2000_0000, 0));
			2: return longint'($urandom);
			default: return WORD_MAX - longint'($urandom_range(255, 0));
		endcase
	endfunction

	// random word, now and then right at the drop threshold
	function automatic longint draw_rnd();
		case ($urandom_range(9, 0))
			0: return 0;
			1: return WORD_MAX;
			2: return (drop_thresh - 1) & WORD_MAX;
			3: return drop_thresh & WORD_MAX;
			default: return longint'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic want_bit,
		input logic got_bit);
		if (mismatch_count < MAX_REPORTS) begin
			$display("mismatch in %s at result %0d: expected %b, got %b",
				what, results_seen, want_bit, got_bit);
		end
		mismatch_count++;
	endtask

	// one sample transaction; entered and left at a falling edge
	task automatic send_sample(input longint inc, input longint off, input longint rnd);
		logic signed [INC_BITS-1:0] inc_f;
		logic signed [OFF_BITS-1:0] off_f;
		logic [RND_BITS-1:0]        rnd_f;
		logic [S_DATA_BITS-1:0]     word;
		int                         gap;
		inc_f = inc[INC_BITS-1:0];
		off_f = off[OFF_BITS-1:0];
		rnd_f = rnd[RND_BITS-1:0];
		word  = '0;
		word[INC_BITS-1:0]                   = inc_f;
		word[INC_BITS +: OFF_BITS]           = off_f;
		word[INC_BITS+OFF_BITS +: RND_BITS]  = rnd_f;
		gap = draw_wait(tx_idle_on);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  <= word;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		pending_flags.push_back(next_impulse_flags(longint'(inc_f), longint'(off_f),
			longint'(rnd_f)));
		@(negedge clk);
	endtask

	// stop offering and wait for every result
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending_flags.size() != 0);
	endtask

	task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx, input longint data);
		cfg_index <= idx;
		cfg_data  <= data[CFG_DATA_BITS-1:0];
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		case (idx)
			CFG_DROP_PROBABILITY: drop_thresh = data & DROP_MASK;
			CFG_START_OFFSET: begin
				start_offset_reg = data & WORD_MAX;
				reload_phase();
			end
			CFG_START_NEGATIVE: begin
				start_neg_reg = data[0];
				reload_phase();
			end
			default: ;
		endcase
	endtask

	task automatic apply_settings(input longint drop, input longint soff, input bit sneg);
		drain_results();
		cfg_write(CFG_DROP_PROBABILITY, drop);
		cfg_write(CFG_START_OFFSET, soff);
		cfg_write(CFG_START_NEGATIVE, longint'(sneg));
	endtask

	// tone runs with random content, broken by noise and sign flips
	task automatic random_samples(input int count);
		int     sent;
		int     run_len;
		int     k;
		bit     neg;
		bit     drift;
		longint mag;
		longint inc;
		longint off;
		sent = 0;
		while (sent < count) begin
			run_len = $urandom_range(40, 4);
			neg     = 1'($urandom_range(1, 0));
			mag     = draw_magnitude();
			off     = $urandom_range(1, 0) ? rand_bits(OFF_BITS) : rand_bits(12);
			drift   = ($urandom_range(2, 0) == 0);
			for (k = 0; k < run_len && sent < count; k++) begin
				if ($urandom_range(7, 0) == 0) begin
					inc = draw_magnitude();
					if ($urandom_range(1, 0)) begin
						inc = -inc;
					end
					send_sample(inc, rand_bits(OFF_BITS), longint'($urandom));
				end else begin
					if ($urandom_range(15, 0) == 0) begin
						neg = !neg;
					end
					if (drift) begin
						off = off + longint'($urandom_range(32'h0010_0000, 0)) - 64'sh8_0000;
					end
					inc = neg ? -mag : mag;
					send_sample(inc, off, draw_rnd());
				end
				sent++;
			end
		end
	endtask

	// state out of reset: phase at one, positive direction
	task automatic test_default_state();
		send_sample(0, 0, 0);
		send_sample(WORD_MAX, 0, WORD_MAX);
		send_sample(WORD_MAX, 0, 0);
		send_sample(-WORD_MAX, 0, 32'h8000_0000);
		send_sample(-WORD_MAX, 0, 0);
		send_sample(0, OFF_MAX, WORD_MAX);
		send_sample(0, OFF_MIN, 0);
		send_sample(WORD_MAX, OFF_MAX, 1);
		send_sample(-WORD_MAX, OFF_MIN, 5);
		send_sample(1, 0, 0);
	endtask

	// always drop, then a threshold of one either side
	task automatic test_dropout_limits();
		apply_settings(DROP_ALWAYS, 0, 1'b0);
		send_sample(WORD_MAX, 0, WORD_MAX);
		send_sample(WORD_MAX, 0, 0);
		apply_settings(1, 0, 1'b0);
		send_sample(WORD_MAX, 0, 0);
		send_sample(WORD_MAX, 0, 1);
	endtask

	// reload of the phase state from the start registers
	task automatic test_start_registers();
		apply_settings(0, WORD_MAX, 1'b1);
		send_sample(-WORD_MAX, 0, 0);
		send_sample(-1, 0, 0);
		// zero phase with negative direction fires at once
		apply_settings(0, 0, 1'b1);
		send_sample(-1, 0, 0);
		send_sample(-(64'sd1 <<< 31), 0, 0);
		drain_results();
		cfg_write(CFG_SPARE_INDEX, rand_bits(CFG_DATA_BITS));
		send_sample(-1, 0, 0);
		apply_settings(0, 0, 1'b0);
		send_sample(0, 0, 0);
		apply_settings(0, 32'h8000_0000, 1'b0);
		send_sample(0, 0, 0);
	endtask

	task automatic test_random_phases();
		int     phase_no;
		longint drop;
		longint soff;
		for (phase_no = 0; phase_no < 6; phase_no++) begin
			case ($urandom_range(5, 0))
				0: drop = 0;
				1: drop = DROP_ALWAYS;
				2: drop = 64'sh8000_0000;
				3: drop = 1;
				default: drop = longint'($urandom);
			endcase
			case ($urandom_range(3, 0))
				0: soff = 0;
				1: soff = WORD_MAX;
				default: soff = longint'($urandom);
			endcase
			apply_settings(drop, soff, 1'($urandom_range(1, 0)));
			tx_idle_on = ($urandom_range(3, 0) != 0);
			rx_idle_on = ($urandom_range(3, 0) != 0);
			random_samples(110);
		end
	endtask

	// long sink hold while samples keep coming, so the input stalls
	task automatic test_input_stall();
		drain_results();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		hold_len   = HOLD_CYCLES;
		random_samples(40);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// result sink with random stalls
	initial begin : result_sink
		int wait_n;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			wait_n   = draw_wait(rx_idle_on) + hold_len;
			hold_len = 0;
			if (wait_n > 0) begin
				m_tready <= 1'b0;
				repeat (wait_n) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	// compare each result transaction with the oldest pending flags
	always @(posedge clk) begin : check_results
		flags_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_flags.size() == 0) begin
				report_mismatch("result with nothing pending", 1'b0, m_tdata[0]);
			end else begin
				want = pending_flags.pop_front();
				if (m_tdata[0] !== want.impulse) begin
					report_mismatch("impulse", want.impulse, m_tdata[0]);
				end
				if (m_tdata[1] !== want.dropped) begin
					report_mismatch("dropped", want.dropped, m_tdata[1]);
				end
			end
			results_seen++;
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		s_tdata   = '0;
		s_tvalid  = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		drop_thresh      = 0;
		start_offset_reg = 0;
		start_neg_reg    = 1'b0;
		reload_phase();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_default_state();
		test_dropout_limits();
		test_start_registers();
		test_random_phases();
		test_input_stall();

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/itrd_pkg.sv
rtl/itrd_phase.sv
rtl/impulse_train_with_random_dropout.sv
sim/impulse_train_with_random_dropout_tb.sv
